// ===== rtl/core/rem_pkg.sv =====
// ----------------------------------------------------------------------------
// rem_pkg
// Shared types and constants of the row end mode detector: configuration
// register indexes, the configuration set, the frame record and the status
// result.
// ----------------------------------------------------------------------------
package rem_pkg;

	localparam int CountW = 17;
	localparam int ProdW  = 26;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 16;

	localparam logic [CfgIdxW-1:0] CFG_GROUND_THRESHOLD  = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_END_RATIO         = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_START_RATIO       = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_END_COUNT_LIMIT   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_START_COUNT_LIMIT = 3'd4;

	localparam logic signed [15:0] GROUND_THRESHOLD_RST = 16'sd50;
	localparam logic [8:0] END_RATIO_RST = 9'd51;
	localparam logic [8:0] START_RATIO_RST = 9'd192;
	localparam logic [7:0] END_COUNT_LIMIT_RST = 8'd20;
	localparam logic [7:0] START_COUNT_LIMIT_RST = 8'd20;
	localparam logic [7:0] HYST_MAX = 8'd255;

	typedef struct packed {
		logic signed [15:0] ground_threshold;
		logic [8:0]         end_ratio;
		logic [8:0]         start_ratio;
		logic [7:0]         end_count_limit;
		logic [7:0]         start_count_limit;
	} rem_cfg_t;

	typedef struct packed {
		logic [CountW-1:0] valid_points;
		logic [CountW-1:0] ahead_points;
	} rem_frame_t;

	typedef struct packed {
		logic              turning_mode;
		logic              direction_forward;
		logic              mode_changed;
		logic [CountW-1:0] valid_points;
		logic [CountW-1:0] ahead_points;
	} rem_result_t;

endpackage

// ===== rtl/core/row_end_mode_detector.sv =====
// ----------------------------------------------------------------------------
// row_end_mode_detector
// Lidar row end / row start detector with driving and turning modes.
// ----------------------------------------------------------------------------
// Points are taken one per cycle while full is low. Each point is classified
// as it arrives and added to the frame's valid/ahead counts; the last point
// of a frame closes a frame record into a two-entry queue. The evaluator
// takes one frame record per cycle while the result queue has room, forms the
// two ratio products in one register stage and updates the mode on the way
// into a two-entry result queue, so a status item passes through the frame
// queue, the product register and the result queue before it reaches the
// result ports. Input is held off only while both frame records are still
// waiting, which happens when the result side is not popped. Configuration
// writes are taken every cycle.
module row_end_mode_detector #(
	parameter int MAX_POINTS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_z,
	input  logic               last_point,
	output logic               empty,
	input  logic               pop,
	output logic               turning_mode,
	output logic               direction_forward,
	output logic               mode_changed,
	output logic [16:0]        valid_points,
	output logic [16:0]        ahead_points,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	import rem_pkg::*;

	localparam logic [CountW-1:0] CountCap =
		(MAX_POINTS < 131071) ? CountW'(MAX_POINTS) : CountW'(131071);

	rem_cfg_t    cfg_q;
	logic        accept;
	logic        frame_push;
	rem_frame_t  frame_in;
	logic        frame_full;
	logic        frame_empty;
	logic        frame_pop;
	rem_frame_t  frame_out;
	logic        result_full;
	logic        result_push;
	rem_result_t result_in;
	rem_result_t result_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ground_threshold  <= GROUND_THRESHOLD_RST;
			cfg_q.end_ratio         <= END_RATIO_RST;
			cfg_q.start_ratio       <= START_RATIO_RST;
			cfg_q.end_count_limit   <= END_COUNT_LIMIT_RST;
			cfg_q.start_count_limit <= START_COUNT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GROUND_THRESHOLD:  cfg_q.ground_threshold  <= cfg_data;
				CFG_END_RATIO:         cfg_q.end_ratio         <= cfg_data[8:0];
				CFG_START_RATIO:       cfg_q.start_ratio       <= cfg_data[8:0];
				CFG_END_COUNT_LIMIT:   cfg_q.end_count_limit   <= cfg_data[7:0];
				CFG_START_COUNT_LIMIT: cfg_q.start_count_limit <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign full   = frame_full;
	assign accept = push && !frame_full;

	rem_front #(
		.COUNT_CAP(CountCap)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.point_x    (point_x),
		.point_z    (point_z),
		.last_point (last_point),
		.frame_push (frame_push),
		.frame      (frame_in)
	);

	rem_fifo #(
		.WIDTH($bits(rem_frame_t)),
		.DEPTH(2)
	) u_frame_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (frame_push),
		.wdata  (frame_in),
		.full   (frame_full),
		.pop    (frame_pop),
		.rdata  (frame_out),
		.empty  (frame_empty)
	);

	rem_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.frame_empty (frame_empty),
		.frame       (frame_out),
		.frame_pop   (frame_pop),
		.result_full (result_full),
		.result_push (result_push),
		.result      (result_in)
	);

	rem_fifo #(
		.WIDTH($bits(rem_result_t)),
		.DEPTH(2)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (result_push),
		.wdata  (result_in),
		.full   (result_full),
		.pop    (pop),
		.rdata  (result_out),
		.empty  (empty)
	);

	assign turning_mode      = result_out.turning_mode;
	assign direction_forward = result_out.direction_forward;
	assign mode_changed      = result_out.mode_changed;
	assign valid_points      = result_out.valid_points;
	assign ahead_points      = result_out.ahead_points;

endmodule

// ===== rtl/core/rem_fifo.sv =====
// ----------------------------------------------------------------------------
// rem_fifo
// Small register queue with push/full and pop/empty sides; the head entry is
// presented while empty is low.
// ----------------------------------------------------------------------------
module rem_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("push into full queue");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> !full) else $error("queue still full after pop");
	a_push_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> !empty) else $error("item lost on push");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FullCnt) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/rem_front.sv =====
// ----------------------------------------------------------------------------
// rem_front
// Point classifier: drops ground points, counts valid and ahead points with
// saturation and hands one frame record on to the queue at the last point.
// ----------------------------------------------------------------------------
module rem_front #(
	parameter logic [16:0] COUNT_CAP = 17'd65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rem_pkg::rem_cfg_t     cfg,
	input  logic                  accept,
	input  logic signed [15:0]    point_x,
	input  logic signed [15:0]    point_z,
	input  logic                  last_point,
	output logic                  frame_push,
	output rem_pkg::rem_frame_t   frame
);

	import rem_pkg::*;

	logic [CountW-1:0] valid_q;
	logic [CountW-1:0] ahead_q;
	logic              non_ground;
	logic              ahead;
	logic [CountW-1:0] valid_nx;
	logic [CountW-1:0] ahead_nx;

	assign non_ground = !(point_z < cfg.ground_threshold);
	assign ahead      = non_ground && !point_x[15] && (point_x != '0);
	assign valid_nx   = (non_ground && valid_q != COUNT_CAP) ? valid_q + 1'b1 : valid_q;
	assign ahead_nx   = (ahead && ahead_q != COUNT_CAP) ? ahead_q + 1'b1 : ahead_q;

	assign frame_push         = accept && last_point;
	assign frame.valid_points = valid_nx;
	assign frame.ahead_points = ahead_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ahead_q <= '0;
		end else if (accept) begin
			if (last_point) begin
				valid_q <= '0;
				ahead_q <= '0;
			end else begin
				valid_q <= valid_nx;
				ahead_q <= ahead_nx;
			end
		end
	end

endmodule

// ===== rtl/core/rem_back.sv =====
// ----------------------------------------------------------------------------
// rem_back
// Frame evaluator: scales the ratio thresholds by the valid count, then runs
// the driving/turning hysteresis and emits one status item per frame.
// ----------------------------------------------------------------------------
module rem_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rem_pkg::rem_cfg_t     cfg,
	input  logic                  frame_empty,
	input  rem_pkg::rem_frame_t   frame,
	output logic                  frame_pop,
	input  logic                  result_full,
	output logic                  result_push,
	output rem_pkg::rem_result_t  result
);

	import rem_pkg::*;

	logic              valid_s1;
	rem_frame_t        frame_s1;
	logic [ProdW-1:0]  end_prod_s1;
	logic [ProdW-1:0]  start_prod_s1;

	logic              turning_q;
	logic              forward_q;
	logic [7:0]        end_cnt_q;
	logic [7:0]        start_cnt_q;

	logic              load;
	logic [ProdW-1:0]  scaled_ahead;
	logic              nonempty;
	logic              low;
	logic              high;
	logic [7:0]        end_step;
	logic [7:0]        start_step;
	logic              turning_nx;
	logic              forward_nx;
	logic [7:0]        end_cnt_nx;
	logic [7:0]        start_cnt_nx;
	logic              changed;

	assign result_push = valid_s1 && !result_full;
	assign load        = !frame_empty && (!valid_s1 || result_push);
	assign frame_pop   = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (result_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_s1      <= frame;
			end_prod_s1   <= ProdW'(cfg.end_ratio) * ProdW'(frame.valid_points);
			start_prod_s1 <= ProdW'(cfg.start_ratio) * ProdW'(frame.valid_points);
		end
	end

	assign scaled_ahead = ProdW'({frame_s1.ahead_points, 8'd0});
	assign nonempty     = (frame_s1.valid_points != '0);
	assign low          = nonempty && (scaled_ahead < end_prod_s1);
	assign high         = nonempty && (scaled_ahead > start_prod_s1);

	always_comb begin
		end_step     = end_cnt_q;
		start_step   = start_cnt_q;
		turning_nx   = turning_q;
		forward_nx   = forward_q;
		end_cnt_nx   = end_cnt_q;
		start_cnt_nx = start_cnt_q;
		changed      = 1'b0;
		if (!turning_q) begin
			if (low) begin
				end_step = (end_cnt_q != HYST_MAX) ? end_cnt_q + 1'b1 : end_cnt_q;
			end else if (end_cnt_q != '0) begin
				end_step = end_cnt_q - 1'b1;
			end
			end_cnt_nx = end_step;
			if (end_step > cfg.end_count_limit) begin
				turning_nx = 1'b1;
				end_cnt_nx = '0;
				changed    = 1'b1;
			end
		end else begin
			if (high) begin
				start_step = (start_cnt_q != HYST_MAX) ? start_cnt_q + 1'b1 : start_cnt_q;
			end else if (start_cnt_q != '0) begin
				start_step = start_cnt_q - 1'b1;
			end
			start_cnt_nx = start_step;
			if (start_step > cfg.start_count_limit) begin
				turning_nx   = 1'b0;
				forward_nx   = !forward_q;
				start_cnt_nx = '0;
				changed      = 1'b1;
			end
		end
	end

	assign result.turning_mode      = turning_nx;
	assign result.direction_forward = forward_nx;
	assign result.mode_changed      = changed;
	assign result.valid_points      = frame_s1.valid_points;
	assign result.ahead_points      = frame_s1.ahead_points;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turning_q   <= 1'b0;
			forward_q   <= 1'b1;
			end_cnt_q   <= '0;
			start_cnt_q <= '0;
		end else if (result_push) begin
			turning_q   <= turning_nx;
			forward_q   <= forward_nx;
			end_cnt_q   <= end_cnt_nx;
			start_cnt_q <= start_cnt_nx;
		end
	end

`ifndef SYNTHESIS
	a_turn_clears_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_push && changed && turning_nx) |=> (end_cnt_q == '0))
		else $error("end counter not cleared on entering turning mode");
	a_drive_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		(result_push && changed && !turning_nx) |=> (forward_q != $past(forward_q)))
		else $error("direction not toggled on leaving turning mode");
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!result_push |=> $stable(turning_q) && $stable(forward_q))
		else $error("mode changed without a frame");
`endif

endmodule
